[hdl/rxsort_pkg.sv]
// rxsort_pkg: shared types and constants for the record exchange sorter.
// No dependencies; used by rxsort_ram and record_exchange_sort_by_score.
`default_nettype none

package rxsort_pkg;

	localparam int DEPTH_DEF = 64;

	// one input word: a student record plus the end-of-set mark
	typedef struct packed {
		logic signed [31:0] student_id;
		logic [63:0]        name_head;
		logic [7:0]         name_tail;
		logic signed [31:0] score_value;
		logic               final_record;
	} in_word_t;

	// one output word: a record at its sorted position plus run flags
	typedef struct packed {
		logic signed [31:0] out_id;
		logic [63:0]        out_name_head;
		logic [7:0]         out_name_tail;
		logic signed [31:0] out_score;
		logic               run_end;
		logic               dropped_flag;
	} out_word_t;

	// record as held in the store
	typedef struct packed {
		logic signed [31:0] id;
		logic [63:0]        name_head;
		logic [7:0]         name_tail;
		logic signed [31:0] score;
	} rec_t;

endpackage

`default_nettype wire

[hdl/record_exchange_sort_by_score.sv]
// Record exchange sorter: collects records, sorts by score descending, emits them.
// Start takes a word while idle; a word marked final starts the sort of the n held records.
// Sort and output do one compare per cycle through the single store read port; each
// position is emitted as soon as it is settled, one result per strobe, and the receiver
// cannot stall. busy stays high from the final word on.
// Async reset clears sequencer, count and overflow flag; store kept. Needs rxsort_pkg/_ram.
`default_nettype none

module record_exchange_sort_by_score #(
	parameter int DEPTH = rxsort_pkg::DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire rxsort_pkg::in_word_t entry,
	output logic                 result_strobe,
	output rxsort_pkg::out_word_t result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_HEAD  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_EMIT  = 3'd4;

	logic [2:0]        state_q;
	logic [CW-1:0]     cnt_q;
	logic              ovf_q;
	logic [AW-1:0]     i_q;
	logic [AW-1:0]     j_q;
	rxsort_pkg::rec_t  cur_q;
	logic              strobe_q;
	rxsort_pkg::out_word_t out_q;

	logic              we;
	logic [AW-1:0]     waddr;
	rxsort_pkg::rec_t  wdata;
	logic [AW-1:0]     raddr;
	rxsort_pkg::rec_t  rdata;

	logic              accept;
	logic              has_room;
	logic              last_i;
	logic              last_j;
	logic              take;
	rxsort_pkg::rec_t  in_rec;

	assign accept   = start && (state_q == ST_IDLE);
	assign has_room = cnt_q < CW'(DEPTH);
	assign last_i   = (CW'(i_q) + CW'(1)) == cnt_q;
	assign last_j   = (CW'(j_q) + CW'(1)) == cnt_q;
	// strictly greater later score moves up; the held record goes back to slot j
	assign take     = $signed(rdata.score) > $signed(cur_q.score);

	assign in_rec.id        = entry.student_id;
	assign in_rec.name_head = entry.name_head;
	assign in_rec.name_tail = entry.name_tail;
	assign in_rec.score     = entry.score_value;

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = in_rec;
		raddr = i_q;
		unique case (state_q) inside
			ST_IDLE: begin
				we = accept && has_room;
			end
			ST_HEAD: begin
				raddr = i_q + AW'(1);
			end
			ST_SCAN: begin
				we    = take;
				waddr = j_q;
				wdata = cur_q;
				raddr = j_q + AW'(1);
			end
			ST_FETCH, ST_EMIT: begin
				raddr = i_q;
			end
			default: begin
				raddr = i_q;
			end
		endcase
	end

	rxsort_ram #(
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (has_room) begin
							cnt_q <= cnt_q + CW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (entry.final_record) begin
							i_q     <= '0;
							state_q <= ST_FETCH;
						end
					end
				end
				ST_FETCH: begin
					state_q <= ST_HEAD;
				end
				ST_HEAD: begin
					if (last_i) begin
						state_q <= ST_EMIT;
					end else begin
						j_q     <= i_q + AW'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (last_j) begin
						state_q <= ST_EMIT;
					end else begin
						j_q <= j_q + AW'(1);
					end
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					if (last_i) begin
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						i_q     <= i_q + AW'(1);
						state_q <= ST_FETCH;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// held record for position i and the output word
	always_ff @(posedge clk) begin
		if (state_q == ST_HEAD) begin
			cur_q <= rdata;
		end else if ((state_q == ST_SCAN) && take) begin
			cur_q <= rdata;
		end
		if (state_q == ST_EMIT) begin
			out_q.out_id        <= cur_q.id;
			out_q.out_name_head <= cur_q.name_head;
			out_q.out_name_tail <= cur_q.name_tail;
			out_q.out_score     <= cur_q.score;
			out_q.run_end       <= last_i;
			out_q.dropped_flag  <= ovf_q;
		end
	end

	assign busy          = state_q != ST_IDLE;
	assign result_strobe = strobe_q;
	assign result        = out_q;

endmodule

`default_nettype wire

[hdl/rxsort_ram.sv]
// rxsort_ram: record store, one write port and one registered read port.
// Depends on rxsort_pkg for the record type.
`default_nettype none

module rxsort_ram #(
	parameter int DEPTH = rxsort_pkg::DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire rxsort_pkg::rec_t wdata,
	input  wire logic [AW-1:0]    raddr,
	output rxsort_pkg::rec_t      rdata
);

	rxsort_pkg::rec_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
